>>> hdl/cpt_pkg.sv
package cpt_pkg;

    // multiplier partial products are MUL_CHUNK x MUL_CHUNK
    localparam int MUL_CHUNK   = 24;
    localparam int MUL_LAT     = 5;
    localparam int RATIO_BITS  = 32;
    localparam int DIV_LAT     = RATIO_BITS + 2;
    localparam int QUEUE_DEPTH = 4;

    // front: diff, mul, sum, mul, sub, classify
    localparam int FRONT_LAT = 2 * MUL_LAT + 4;
    // back: divider, param select, mul, sum, saturate
    localparam int BACK_LAT  = DIV_LAT + MUL_LAT + 3;
    // accept edge to the edge that takes the result word
    localparam int TOTAL_LAT = FRONT_LAT + 1 + BACK_LAT;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> hdl/cpt_mul.sv
module cpt_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                      i_clk,
    input  logic signed [AW-1:0]      i_a,
    input  logic signed [BW-1:0]      i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int CK = cpt_pkg::MUL_CHUNK;
    localparam int NA = (AW + CK - 1) / CK;
    localparam int NB = (BW + CK - 1) / CK;
    localparam int PW = AW + BW;

    logic [NA*CK-1:0] r_ma;
    logic [NB*CK-1:0] r_mb;
    logic [3:0]       r_neg;
    logic [2*CK-1:0]  r_pp [NA][NB];
    logic [PW-1:0]    r_row [NA];
    logic [PW-1:0]    n_row [NA];
    logic [PW-1:0]    r_mag;
    logic [PW-1:0]    n_mag;

    // sign-magnitude: magnitudes multiplied in chunks, sign applied at the end
    always_ff @(posedge i_clk) begin
        r_ma  <= (NA*CK)'(i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a));
        r_mb  <= (NB*CK)'(i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b));
        r_neg <= {r_neg[2:0], i_a[AW-1] ^ i_b[BW-1]};
    end

    for (genvar i = 0; i < NA; i++) begin : g_pa
        for (genvar j = 0; j < NB; j++) begin : g_pb
            always_ff @(posedge i_clk) begin
                r_pp[i][j] <= r_ma[i*CK +: CK] * r_mb[j*CK +: CK];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * CK));
            end
        end
    end

    always_comb begin
        n_mag = '0;
        for (int i = 0; i < NA; i++) begin
            n_mag = n_mag + (r_row[i] << (i * CK));
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_mag <= n_mag;
        o_p   <= r_neg[3] ? $signed(-r_mag) : $signed(r_mag);
    end

endmodule

>>> hdl/cpt_div.sv
module cpt_div #(
    parameter int NW = 137
) (
    input  logic                              i_clk,
    input  logic signed [NW-1:0]              i_num,
    input  logic signed [NW-1:0]              i_den,
    output logic [cpt_pkg::RATIO_BITS:0]      o_q
);

    localparam int RB = cpt_pkg::RATIO_BITS;

    logic [NW-1:0] r_rem  [RB+1];
    logic [NW-1:0] r_den  [RB+1];
    logic [RB-1:0] r_q    [RB+1];
    logic          r_zero [RB+1];
    logic          r_one  [RB+1];

    // clamp cases decided up front; the restoring steps' quotient is used only for 0 < num < den
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= $unsigned(i_num);
        r_den[0]  <= $unsigned(i_den);
        r_q[0]    <= '0;
        r_zero[0] <= i_den[NW-1] || (i_den == '0) || i_num[NW-1] || (i_num == '0);
        r_one[0]  <= (i_num >= i_den);
    end

    for (genvar j = 1; j <= RB; j++) begin : g_step
        logic [NW-1:0] w_rem2;
        logic          w_ge;
        assign w_rem2 = {r_rem[j-1][NW-2:0], 1'b0};
        assign w_ge   = (w_rem2 >= r_den[j-1]);
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_ge ? (w_rem2 - r_den[j-1]) : w_rem2;
            r_den[j]  <= r_den[j-1];
            r_q[j]    <= {r_q[j-1][RB-2:0], w_ge};
            r_zero[j] <= r_zero[j-1];
            r_one[j]  <= r_one[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zero[RB]) begin
            o_q <= '0;
        end else if (r_one[RB]) begin
            o_q <= {1'b1, {RB{1'b0}}};
        end else begin
            o_q <= {1'b0, r_q[RB]};
        end
    end

endmodule

>>> hdl/cpt_front.sv
module cpt_front #(
    parameter int  COORD_WIDTH = 32,
    localparam int DW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * DW + 2,
    localparam int QW  = 2 * PW + 1,
    localparam int PLW = 3 * COORD_WIDTH + 6 * DW,
    localparam int JW  = 4 * QW + 1 + PLW
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [COORD_WIDTH-1:0]  i_p  [3],
    input  logic signed [COORD_WIDTH-1:0]  i_va [3],
    input  logic signed [COORD_WIDTH-1:0]  i_vb [3],
    input  logic signed [COORD_WIDTH-1:0]  i_vc [3],
    output logic                           o_valid,
    output logic [JW-1:0]                  o_job
);

    localparam int W   = COORD_WIDTH;
    localparam int ML  = cpt_pkg::MUL_LAT;
    localparam int FL  = cpt_pkg::FRONT_LAT;
    localparam int SDW = 4 * PW + 2 * QW + 2;

    logic [FL-1:0] r_v;

    logic signed [W-1:0]  r_va [3];
    logic signed [DW-1:0] r_e0 [3];
    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_dv [3];

    logic signed [2*DW-1:0] m_a [3];
    logic signed [2*DW-1:0] m_b [3];
    logic signed [2*DW-1:0] m_c [3];
    logic signed [2*DW-1:0] m_d [3];
    logic signed [2*DW-1:0] m_e [3];

    logic signed [PW-1:0] r_a, r_b, r_c, r_d, r_e;
    logic signed [2*PW-1:0] m_ac, m_bb, m_be, m_cd, m_bd, m_ae;

    logic [PLW-1:0] n_pl;
    logic [PLW-1:0] r_pl [FL-2];

    logic signed [QW-1:0] n_far_num, n_far_den, n_gad;
    logic [SDW-1:0] n_sd;
    logic [SDW-1:0] r_sd [ML];
    logic [SDW-1:0] r_sx;
    logic signed [QW-1:0] r_det, r_s, r_t;

    logic signed [PW-1:0] x_a, x_c, x_d, x_e;
    logic signed [QW-1:0] x_far_num, x_far_den, x_negd, x_nege;
    logic                 x_gce, x_gad;
    logic signed [QW:0]   x_st;
    logic                 x_lt;
    logic signed [QW-1:0] n_sn, n_sdn, n_tn, n_tdn;
    logic                 n_om;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FL-2:0], i_valid};
        end
    end
    assign o_valid = r_v[FL-1];

    // edge vectors and offset from the query point
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_va[k] <= i_va[k];
            r_e0[k] <= DW'(i_vb[k]) - DW'(i_va[k]);
            r_e1[k] <= DW'(i_vc[k]) - DW'(i_va[k]);
            r_dv[k] <= DW'(i_va[k]) - DW'(i_p[k]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_dot
        cpt_mul #(.AW(DW), .BW(DW)) u_ma (.i_clk, .i_a(r_e0[k]), .i_b(r_e0[k]), .o_p(m_a[k]));
        cpt_mul #(.AW(DW), .BW(DW)) u_mb (.i_clk, .i_a(r_e0[k]), .i_b(r_e1[k]), .o_p(m_b[k]));
        cpt_mul #(.AW(DW), .BW(DW)) u_mc (.i_clk, .i_a(r_e1[k]), .i_b(r_e1[k]), .o_p(m_c[k]));
        cpt_mul #(.AW(DW), .BW(DW)) u_md (.i_clk, .i_a(r_e0[k]), .i_b(r_dv[k]), .o_p(m_d[k]));
        cpt_mul #(.AW(DW), .BW(DW)) u_me (.i_clk, .i_a(r_e1[k]), .i_b(r_dv[k]), .o_p(m_e[k]));
    end

    always_ff @(posedge i_clk) begin
        r_a <= PW'(m_a[0]) + PW'(m_a[1]) + PW'(m_a[2]);
        r_b <= PW'(m_b[0]) + PW'(m_b[1]) + PW'(m_b[2]);
        r_c <= PW'(m_c[0]) + PW'(m_c[1]) + PW'(m_c[2]);
        r_d <= PW'(m_d[0]) + PW'(m_d[1]) + PW'(m_d[2]);
        r_e <= PW'(m_e[0]) + PW'(m_e[1]) + PW'(m_e[2]);
    end

    cpt_mul #(.AW(PW), .BW(PW)) u_ac (.i_clk, .i_a(r_a), .i_b(r_c), .o_p(m_ac));
    cpt_mul #(.AW(PW), .BW(PW)) u_bb (.i_clk, .i_a(r_b), .i_b(r_b), .o_p(m_bb));
    cpt_mul #(.AW(PW), .BW(PW)) u_be (.i_clk, .i_a(r_b), .i_b(r_e), .o_p(m_be));
    cpt_mul #(.AW(PW), .BW(PW)) u_cd (.i_clk, .i_a(r_c), .i_b(r_d), .o_p(m_cd));
    cpt_mul #(.AW(PW), .BW(PW)) u_bd (.i_clk, .i_a(r_b), .i_b(r_d), .o_p(m_bd));
    cpt_mul #(.AW(PW), .BW(PW)) u_ae (.i_clk, .i_a(r_a), .i_b(r_e), .o_p(m_ae));

    // far-edge terms ride alongside the second multiply
    always_comb begin
        n_far_num = QW'(r_c) + QW'(r_e) - QW'(r_b) - QW'(r_d);
        n_far_den = QW'(r_a) - (QW'(r_b) <<< 1) + QW'(r_c);
        n_gad     = QW'(r_a) + QW'(r_d) - QW'(r_b) - QW'(r_e);
        n_sd = {r_a, r_c, r_d, r_e, n_far_num, n_far_den,
                !n_far_num[QW-1] && (n_far_num != '0),
                !n_gad[QW-1] && (n_gad != '0)};
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pl[k*W +: W]               = r_va[k];
            n_pl[3*W + k*DW +: DW]       = r_e0[k];
            n_pl[3*W + 3*DW + k*DW +: DW] = r_e1[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl[0] <= n_pl;
        for (int i = 1; i < FL - 2; i++) begin
            r_pl[i] <= r_pl[i-1];
        end
        r_sd[0] <= n_sd;
        for (int i = 1; i < ML; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_det <= QW'(m_ac) - QW'(m_bb);
        r_s   <= QW'(m_be) - QW'(m_cd);
        r_t   <= QW'(m_bd) - QW'(m_ae);
        r_sx  <= r_sd[ML-1];
    end

    // region select: each parameter leaves as num/den, zero pair means 0
    always_comb begin
        x_a       = $signed(r_sx[SDW-1 -: PW]);
        x_c       = $signed(r_sx[SDW-1-PW -: PW]);
        x_d       = $signed(r_sx[SDW-1-2*PW -: PW]);
        x_e       = $signed(r_sx[SDW-1-3*PW -: PW]);
        x_far_num = $signed(r_sx[2*QW+1 -: QW]);
        x_far_den = $signed(r_sx[QW+1 -: QW]);
        x_gce     = r_sx[1];
        x_gad     = r_sx[0];
        x_negd    = -QW'(x_d);
        x_nege    = -QW'(x_e);
        x_st      = (QW+1)'(r_s) + (QW+1)'(r_t);
        x_lt      = x_st < (QW+1)'(r_det);
        n_sn  = '0;
        n_sdn = '0;
        n_tn  = '0;
        n_tdn = '0;
        n_om  = 1'b0;
        priority if (x_lt) begin
            priority if (r_s[QW-1]) begin
                if (r_t[QW-1] && x_d[PW-1]) begin
                    n_sn  = x_negd;
                    n_sdn = QW'(x_a);
                end else begin
                    n_tn  = x_nege;
                    n_tdn = QW'(x_c);
                end
            end else if (r_t[QW-1]) begin
                n_sn  = x_negd;
                n_sdn = QW'(x_a);
            end else begin
                n_sn  = r_s;
                n_sdn = r_det;
                n_tn  = r_t;
                n_tdn = r_det;
            end
        end else begin
            priority if (r_s[QW-1]) begin
                if (x_gce) begin
                    n_sn  = x_far_num;
                    n_sdn = x_far_den;
                    n_om  = 1'b1;
                end else begin
                    n_tn  = x_nege;
                    n_tdn = QW'(x_c);
                end
            end else if (r_t[QW-1]) begin
                if (x_gad) begin
                    n_sn  = x_far_num;
                    n_sdn = x_far_den;
                    n_om  = 1'b1;
                end else begin
                    n_sn  = x_negd;
                    n_sdn = QW'(x_a);
                end
            end else begin
                n_sn  = x_far_num;
                n_sdn = x_far_den;
                n_om  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_job <= {n_sn, n_sdn, n_tn, n_tdn, n_om, r_pl[FL-3]};
    end

endmodule

>>> hdl/cpt_queue.sv
module cpt_queue #(
    parameter int  WD    = 8,
    parameter int  DEPTH = 4,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WD-1:0]         i_data,
    output logic                  o_valid,
    output logic [WD-1:0]         o_data,
    output cpt_pkg::t_qstat       o_stat
);

    logic [WD-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_pop;

    // back end never stalls, so the head leaves whenever present
    assign w_pop   = (r_cnt != '0);
    assign o_valid = w_pop;
    assign o_data  = r_mem[r_rp];
    assign o_stat  = '{full: (r_cnt == CW'(DEPTH)), empty: !w_pop};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end

endmodule

>>> hdl/cpt_back.sv
module cpt_back #(
    parameter int  COORD_WIDTH = 32,
    localparam int DW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * DW + 2,
    localparam int QW  = 2 * PW + 1,
    localparam int PLW = 3 * COORD_WIDTH + 6 * DW,
    localparam int JW  = 4 * QW + 1 + PLW
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [JW-1:0]                  i_job,
    output logic                           o_valid,
    output logic signed [COORD_WIDTH-1:0]  o_near [3]
);

    localparam int W   = COORD_WIDTH;
    localparam int RB  = cpt_pkg::RATIO_BITS;
    localparam int ML  = cpt_pkg::MUL_LAT;
    localparam int DL  = cpt_pkg::DIV_LAT;
    localparam int BL  = cpt_pkg::BACK_LAT;
    localparam int MW  = DW + RB + 2;
    localparam int RW  = DW + RB + 4;
    localparam int SHW = RW - RB;
    localparam logic [RW-1:0] HALF = {{(RW-RB){1'b0}}, 1'b1, {(RB-1){1'b0}}};

    logic [BL-1:0] r_v;

    logic signed [QW-1:0] w_sn, w_sd, w_tn, w_td;
    logic [RB:0] w_qs, w_qt;
    logic [PLW:0] r_pl [DL];
    logic [PLW:0] w_pl;

    logic [RB:0]          r_sq, r_tq;
    logic signed [W-1:0]  r_va [3];
    logic signed [DW-1:0] r_e0 [3];
    logic signed [DW-1:0] r_e1 [3];
    logic [3*W-1:0]       r_vd [ML];
    logic [3*W-1:0]       w_vp;

    logic signed [MW-1:0] m_s [3];
    logic signed [MW-1:0] m_t [3];
    logic signed [RW-1:0] r_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[BL-2:0], i_valid};
        end
    end
    assign o_valid = r_v[BL-1];

    assign w_sn = $signed(i_job[PLW+1+3*QW +: QW]);
    assign w_sd = $signed(i_job[PLW+1+2*QW +: QW]);
    assign w_tn = $signed(i_job[PLW+1+QW +: QW]);
    assign w_td = $signed(i_job[PLW+1 +: QW]);

    cpt_div #(.NW(QW)) u_div_s (.i_clk, .i_num(w_sn), .i_den(w_sd), .o_q(w_qs));
    cpt_div #(.NW(QW)) u_div_t (.i_clk, .i_num(w_tn), .i_den(w_td), .o_q(w_qt));

    always_ff @(posedge i_clk) begin
        r_pl[0] <= i_job[PLW:0];
        for (int i = 1; i < DL; i++) begin
            r_pl[i] <= r_pl[i-1];
        end
    end
    assign w_pl = r_pl[DL-1];

    // on the far edge t is one minus s
    always_ff @(posedge i_clk) begin
        r_sq <= w_qs;
        r_tq <= w_pl[PLW] ? ({1'b1, {RB{1'b0}}} - w_qs) : w_qt;
        for (int k = 0; k < 3; k++) begin
            r_va[k] <= $signed(w_pl[k*W +: W]);
            r_e0[k] <= $signed(w_pl[3*W + k*DW +: DW]);
            r_e1[k] <= $signed(w_pl[3*W + 3*DW + k*DW +: DW]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_crd
        cpt_mul #(.AW(DW), .BW(RB+2)) u_ms (
            .i_clk, .i_a(r_e0[k]), .i_b($signed({1'b0, r_sq})), .o_p(m_s[k]));
        cpt_mul #(.AW(DW), .BW(RB+2)) u_mt (
            .i_clk, .i_a(r_e1[k]), .i_b($signed({1'b0, r_tq})), .o_p(m_t[k]));
        assign w_vp[k*W +: W] = r_va[k];
    end

    always_ff @(posedge i_clk) begin
        r_vd[0] <= w_vp;
        for (int i = 1; i < ML; i++) begin
            r_vd[i] <= r_vd[i-1];
        end
    end

    // base with 32 extra fraction bits, plus half for round-to-nearest
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sum[k] <= (RW'($signed(r_vd[ML-1][k*W +: W])) <<< RB)
                        + RW'(m_s[k]) + RW'(m_t[k]) + $signed(HALF);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_sat
        logic [SHW-1:0]   w_sh;
        logic [SHW-W:0]   w_top;
        assign w_sh  = r_sum[k][RW-1:RB];
        assign w_top = w_sh[SHW-1:W-1];
        always_ff @(posedge i_clk) begin
            if ((&w_top) || !(|w_top)) begin
                o_near[k] <= $signed(w_sh[W-1:0]);
            end else if (w_sh[SHW-1]) begin
                o_near[k] <= $signed({1'b1, {(W-1){1'b0}}});
            end else begin
                o_near[k] <= $signed({1'b0, {(W-1){1'b1}}});
            end
        end
    end

endmodule

>>> hdl/closest_point_on_triangle_top.sv
// Closest point on a triangle, signed fixed point. One query per clock: a word is taken
// on any edge with start high and busy low, and its nearest point is shown on o_near_*
// with o_valid high for one cycle. Results leave in accept order and must be taken when
// shown. The latency is set by the two chained multiply stages of the front end (dot
// products, then det/s/t, each split into 24-bit partial products over five stages) and
// the two 32-stage restoring dividers in the back end, one quotient bit per stage. The
// queue between them drains every cycle, so busy stays low in normal operation.
module closest_point_on_triangle_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [COORD_WIDTH-1:0]  i_point_y,
    input  logic signed [COORD_WIDTH-1:0]  i_point_z,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_a_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_a_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_a_z,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_b_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_b_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_b_z,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_c_x,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_c_y,
    input  logic signed [COORD_WIDTH-1:0]  i_vert_c_z,
    output logic                           o_valid,
    output logic signed [COORD_WIDTH-1:0]  o_near_x,
    output logic signed [COORD_WIDTH-1:0]  o_near_y,
    output logic signed [COORD_WIDTH-1:0]  o_near_z
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW + 2;
    localparam int QW  = 2 * PW + 1;
    localparam int PLW = 3 * COORD_WIDTH + 6 * DW;
    localparam int JW  = 4 * QW + 1 + PLW;

    logic signed [COORD_WIDTH-1:0] w_p  [3];
    logic signed [COORD_WIDTH-1:0] w_va [3];
    logic signed [COORD_WIDTH-1:0] w_vb [3];
    logic signed [COORD_WIDTH-1:0] w_vc [3];
    logic signed [COORD_WIDTH-1:0] w_near [3];

    logic            w_accept;
    logic            w_f_valid;
    logic [JW-1:0]   w_f_job;
    logic            w_q_valid;
    logic [JW-1:0]   w_q_job;
    cpt_pkg::t_qstat w_qstat;

    assign w_p  = '{i_point_x, i_point_y, i_point_z};
    assign w_va = '{i_vert_a_x, i_vert_a_y, i_vert_a_z};
    assign w_vb = '{i_vert_b_x, i_vert_b_y, i_vert_b_z};
    assign w_vc = '{i_vert_c_x, i_vert_c_y, i_vert_c_z};

    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;

    cpt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk,
        .i_rst_n,
        .i_valid (w_accept),
        .i_p     (w_p),
        .i_va    (w_va),
        .i_vb    (w_vb),
        .i_vc    (w_vc),
        .o_valid (w_f_valid),
        .o_job   (w_f_job)
    );

    cpt_queue #(.WD(JW), .DEPTH(cpt_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk,
        .i_rst_n,
        .i_push  (w_f_valid),
        .i_data  (w_f_job),
        .o_valid (w_q_valid),
        .o_data  (w_q_job),
        .o_stat  (w_qstat)
    );

    cpt_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk,
        .i_rst_n,
        .i_valid (w_q_valid),
        .i_job   (w_q_job),
        .o_valid (o_valid),
        .o_near  (w_near)
    );

    assign o_near_x = w_near[0];
    assign o_near_y = w_near[1];
    assign o_near_z = w_near[2];

endmodule

>>> hdl/cpt_checker.sv
module cpt_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    localparam int LAT = cpt_pkg::TOTAL_LAT;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result word without a matching accept");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word gave no result");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue backed up");

endmodule

bind closest_point_on_triangle_top cpt_props u_cpt_props (.*);
